// ===== sv/weia_pkg.sv =====
// ----------------------------------------------------------------------------
// weia_pkg: shared types and constants
// Field widths, fixed constants, cell control and sequencer state types for
// the windowed event interval average block.
// ----------------------------------------------------------------------------
package weia_pkg;

   localparam int TIME_W          = 32;
   localparam int KEPT_W          = 7;
   localparam int DIV_STEPS       = 32;
   localparam int DIV_STEP_W      = 5;
   localparam int MIN_KEPT        = 2;
   localparam logic [TIME_W-1:0] PERIOD_AT_RESET = 32'd5000;

   typedef logic [TIME_W-1:0] time_type;

   // control handed to every window cell in each cycle
   typedef struct packed {
      logic shift;   // take the neighbour's entry
      logic load;    // take the new timestamp
   } weia_cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_HOLD
   } weia_state_type;

endpackage

// ===== sv/weia_req_if.sv =====
// ----------------------------------------------------------------------------
// weia_req_if: event channel
// Valid/ready channel carrying one event timestamp per transfer.
// ----------------------------------------------------------------------------
interface weia_req_if import weia_pkg::*; ();

   logic     valid;
   logic     ready;
   time_type event_time;

   modport source (output valid, output event_time, input ready);
   modport sink   (input valid, input event_time, output ready);

endinterface

// ===== sv/weia_rsp_if.sv =====
// ----------------------------------------------------------------------------
// weia_rsp_if: result channel
// Valid/ready channel carrying the interval average, window fill and the
// capacity drop flag.
// ----------------------------------------------------------------------------
interface weia_rsp_if import weia_pkg::*; ();

   logic              valid;
   logic              ready;
   time_type          average_interval;
   logic [KEPT_W-1:0] samples_kept;
   logic              dropped_for_capacity;

   modport source (output valid, output average_interval, output samples_kept,
                   output dropped_for_capacity, input ready);
   modport sink   (input valid, input average_interval, input samples_kept,
                   input dropped_for_capacity, output ready);

endinterface

// ===== sv/weia_cell.sv =====
// ----------------------------------------------------------------------------
// weia_cell: one window cell
// Holds one timestamp; loads the new event or takes its upper neighbour's
// entry when the window advances.
// ----------------------------------------------------------------------------
module weia_cell import weia_pkg::*; (
   input  logic              clock,
   input  weia_cell_ctl_type ctl,
   input  time_type          new_time,
   input  time_type          next_data,
   output time_type          data
);

   time_type data_ff;
   time_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = new_time;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== sv/weia_div.sv =====
// ----------------------------------------------------------------------------
// weia_div: serial divider
// Restoring division of a 32-bit dividend by a narrow divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module weia_div import weia_pkg::*; #(
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  time_type         dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output time_type         quotient
);

   time_type              quo_ff,  quo_in;
   logic [DEN_W-1:0]      rem_ff,  rem_in;
   logic [DEN_W-1:0]      den_ff,  den_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DEN_W:0]        trial;
   logic [DEN_W:0]        diff;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[TIME_W-1]};
      fits    = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[TIME_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/windowed_event_interval_average.sv =====
// ----------------------------------------------------------------------------
// windowed_event_interval_average: sliding window event interval average
// Keeps recent event timestamps in a row of cells, ages out stale ones and
// reports the mean interval across the kept window.
// ----------------------------------------------------------------------------
// Sequence: after an event transfer, the entries aged out by this event are
//   dropped, one cell shift per cycle, then the serial divider forms the mean;
//   the divider is skipped when only one entry is held.
// Throughput: one event at a time; the next event is taken once the result
//   has moved into the output register.
// Reset: synchronous, active high; empties the window and sets the
//   smoothing period to 5000 ms. Cell contents are not cleared.
module windowed_event_interval_average import weia_pkg::*; #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   weia_req_if.sink      req_chan,
   weia_rsp_if.source    rsp_chan,
   input  logic          csr_wr_en,
   input  time_type      csr_wr_data
);

   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   // sequencer and window bookkeeping
   weia_state_type    state_ff,  state_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   time_type          now_ff,    now_in;
   logic              drop_ff,   drop_in;
   time_type          avg_ff,    avg_in;
   time_type          period_ff, period_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   time_type          rsp_avg_ff,   rsp_avg_in;
   logic [CNT_W-1:0]  rsp_cnt_ff,   rsp_cnt_in;
   logic              rsp_drop_ff,  rsp_drop_in;

   // cell row: cell 0 always holds the oldest entry
   weia_cell_ctl_type cell_ctl  [WINDOW_DEPTH];
   time_type          cell_data [WINDOW_DEPTH];
   time_type          cell_next [WINDOW_DEPTH];

   logic              accept;
   logic              full;
   logic              do_shift;
   logic              slot_free;
   time_type          age;
   logic              div_start;
   logic              div_done;
   time_type          div_quo;

   // the input is open only while the sequencer is idle
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign accept    = req_chan.valid && req_chan.ready;
   assign full      = count_ff == CNT_W'(WINDOW_DEPTH);
   assign age       = now_ff - cell_data[0];
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Per-cell control: on a transfer into a full window every cell advances
   // and the top cell takes the new event; otherwise the first free cell
   // takes it. During the age walk every cell advances once per drop.
   generate
      for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
         if (i == WINDOW_DEPTH - 1) begin : g_top
            assign cell_next[i] = '0;
         end else begin : g_mid
            assign cell_next[i] = cell_data[i+1];
         end

         always_comb begin
            cell_ctl[i].shift = do_shift || (accept && full);
            cell_ctl[i].load  = accept &&
                                (full ? (i == WINDOW_DEPTH - 1)
                                      : (count_ff == CNT_W'(i)));
         end

         weia_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[i]),
            .new_time  (req_chan.event_time),
            .next_data (cell_next[i]),
            .data      (cell_data[i])
         );
      end
   endgenerate

   // Mean interval: (newest - oldest) / (count - 1); newest is the event
   // just taken, so the span is the age of cell 0.
   weia_div #(.DEN_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (age),
      .divisor  (count_ff - 1'b1),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      drop_in      = drop_ff;
      avg_in       = avg_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_drop_in  = rsp_drop_ff;
      do_shift     = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // hold the event time; a full window loses its oldest entry
               now_in   = req_chan.event_time;
               drop_in  = full;
               count_in = full ? count_ff : count_ff + 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (count_ff > CNT_W'(MIN_KEPT) && age > period_ff) begin
               // drop the oldest entry, one per cycle
               do_shift = 1'b1;
               count_in = count_ff - 1'b1;
            end else if (count_ff == CNT_W'(1)) begin
               // first event in the window: no interval yet
               avg_in   = '0;
               state_in = ST_HOLD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quo;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // advance into the output register once it is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_cnt_in   = count_ff;
               rsp_drop_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         period_ff    <= PERIOD_AT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      drop_ff     <= drop_in;
      avg_ff      <= avg_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // samples_kept is reported modulo 128, as the field width dictates
   generate
      if (CNT_W >= KEPT_W) begin : g_kept_trunc
         assign rsp_chan.samples_kept = rsp_cnt_ff[KEPT_W-1:0];
      end else begin : g_kept_ext
         assign rsp_chan.samples_kept = KEPT_W'(rsp_cnt_ff);
      end
   endgenerate

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.average_interval     = rsp_avg_ff;
   assign rsp_chan.dropped_for_capacity = rsp_drop_ff;

endmodule

// ===== sv/weia_chk.sv =====
// ----------------------------------------------------------------------------
// weia_chk: port checker
// Watches the top level's channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module weia_chk import weia_pkg::*; #(
   parameter int WINDOW_DEPTH = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input time_type          average_interval,
   input logic [KEPT_W-1:0] samples_kept,
   input logic              dropped_for_capacity
);

   localparam logic WIDE_WINDOW = WINDOW_DEPTH > 127;

   // one event at a time: a transfer closes the input for the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("event taken while another was in progress");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(average_interval)
                                  && $stable(samples_kept))
      else $error("stalled result changed");

   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> WIDE_WINDOW || samples_kept != '0)
      else $error("result reports an empty window");

   // a wide window wraps the reported count, so only a narrow one is checked
   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && samples_kept == KEPT_W'(1) |->
         WIDE_WINDOW || average_interval == '0)
      else $error("single entry window with non-zero interval");

   a_drop_keeps_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped_for_capacity |->
         WIDE_WINDOW || samples_kept >= KEPT_W'(MIN_KEPT))
      else $error("capacity drop with fewer than two entries kept");

endmodule

bind windowed_event_interval_average weia_chk #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_weia_chk (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .average_interval     (rsp_chan.average_interval),
   .samples_kept         (rsp_chan.samples_kept),
   .dropped_for_capacity (rsp_chan.dropped_for_capacity)
);
